// File: rtl/lm_cross_generation_score_top_assert.svh
// assertion macros for the cross-generation scorer
// used by the controller; needs a clock and an active-low reset argument
`ifndef LM_CROSS_GENERATION_SCORE_TOP_ASSERT_SVH
`define LM_CROSS_GENERATION_SCORE_TOP_ASSERT_SVH

// same-cycle implication
`define LCGS_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define LCGS_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/lcgs_pkg.sv
// shared types and constants of the cross-generation scorer
// no dependencies
package lcgs_pkg;

	localparam int MAX_DOCS    = 8;
	localparam int MAX_TERMS   = 256;
	localparam int VOCAB_SIZE  = 4096;

	localparam int DOC_W       = 3;
	localparam int TERM_W      = 12;
	localparam int TF_W        = 16;
	localparam int BG_W        = 16;
	localparam int MU_W        = 16;
	localparam int NDOC_CFG_W  = 4;
	localparam int SIZE_W      = 24;
	localparam int SCORE_W     = 32;

	localparam int TIDX_W      = $clog2(MAX_TERMS);
	localparam int TCNT_W      = $clog2(MAX_TERMS + 1);
	localparam int DCNT_W      = $clog2(MAX_DOCS + 1);
	localparam int DMEM_AW     = DOC_W + TIDX_W;
	localparam int VOCAB_AW    = $clog2(VOCAB_SIZE);

	// log2 unit: input word, exponent and fraction
	localparam int LOG_X_W     = 41;
	localparam int LOG_E_W     = 6;
	localparam int LOG_F_W     = 30;
	localparam int LOG_R_W     = LOG_E_W + LOG_F_W;
	localparam int MANT_W      = 32;

	localparam int LN2_W       = 28;
	localparam logic [LN2_W-1:0] LN2_Q28 = 28'd186065279;

	localparam int MAG_W       = 36;
	localparam int DVD_W       = MAG_W + TF_W;
	localparam int DVS_W       = SIZE_W + 6;
	localparam int QUO_W       = 31;
	localparam int SUM_W       = 33;

	localparam logic [SIZE_W-1:0] SIZE_MAX = '1;

	// actions
	localparam logic [1:0] ACT_BG    = 2'd0;
	localparam logic [1:0] ACT_APP   = 2'd1;
	localparam logic [1:0] ACT_SCORE = 2'd2;
	localparam logic [1:0] ACT_NOP   = 2'd3;

	// configuration register select (paddr bit 2)
	localparam int  PADDR_W  = 3;
	localparam logic REG_MU   = 1'b0;
	localparam logic REG_DOCS = 1'b1;

	typedef struct packed {
		logic [1:0]        action;
		logic [DOC_W-1:0]  doc_index;
		logic [TERM_W-1:0] term_index;
		logic [TF_W-1:0]   term_freq;
		logic [BG_W-1:0]   background_prob;
	} lcgs_in_t;

	typedef struct packed {
		logic [DOC_W-1:0]          source_doc;
		logic [DOC_W-1:0]          model_doc;
		logic signed [SCORE_W-1:0] log_score;
		logic                      zero_factor;
		logic                      last;
	} lcgs_out_t;

	typedef struct packed {
		logic wr_bg;
		logic wr_app;
		logic req_load;
		logic use_i;
		logic inc_i;
		logic doc_load;
		logic log_start;
		logic log_sel_num;
		logic ld_latch;
		logic inc_m;
		logic inc_k;
		logic use_tf;
		logic num_latch;
		logic set_zero;
		logic mul1;
		logic mul2;
		logic div_start;
		logic acc;
		logic emit;
	} lcgs_cmd_t;

	typedef struct packed {
		logic req_ok;
		logic i_done;
		logic i_is_src;
		logic m_end;
		logic k_end;
		logic a_lt_b;
		logic a_gt_b;
		logic src_tf_zero;
		logic num_zero;
		logic log_done;
		logic log_busy;
		logic div_done;
	} lcgs_sts_t;

endpackage

// File: rtl/lm_cross_generation_score_top.sv
// Dirichlet-smoothed cross-generation scorer, top level: configuration port and wiring.
// Depends on lcgs_pkg, lcgs_ctrl and lcgs_datapath.
// Loads and appends never raise busy. A score request keeps busy high until its last
// result: per model document it takes the log of the denominator (at most 24 normalising
// shifts, as the denominator is at least 2^16) and closes it, then the merge steps past
// each skipped model term and works through each source term (up to 40 normalising shifts
// and 30 squarings in the shared log2 unit, the multiply steps and the bit-serial divider).
// Each result is shown for one cycle with result_valid and must be taken in that cycle;
// the receiver cannot stall them.
module lm_cross_generation_score_top import lcgs_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               start,
	output logic               busy,
	input  lcgs_in_t           item,
	output lcgs_out_t          result,
	output logic               result_valid
);

	logic [MU_W-1:0]       mu_q;
	logic [NDOC_CFG_W-1:0] docs_q;
	logic [MU_W-1:0]       mu_eff;
	logic [DCNT_W-1:0]     ndocs;
	lcgs_cmd_t             cmd;
	lcgs_sts_t             sts;

	// configuration registers, written on the access phase of a transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mu_q   <= MU_W'(1000);
			docs_q <= NDOC_CFG_W'(MAX_DOCS);
		end else if (psel && penable && pwrite) begin
			case (paddr[2])
				REG_MU:   mu_q   <= pwdata[MU_W-1:0];
				REG_DOCS: docs_q <= pwdata[NDOC_CFG_W-1:0];
				default: ;
			endcase
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_DOCS) ? 32'(docs_q) : 32'(mu_q);

	// effective mu and active document count
	assign mu_eff = (mu_q == '0) ? MU_W'(1) : mu_q;
	assign ndocs  = (docs_q > NDOC_CFG_W'(MAX_DOCS)) ? DCNT_W'(MAX_DOCS) : DCNT_W'(docs_q);

	lcgs_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.action (item.action),
		.busy   (busy),
		.cmd    (cmd),
		.sts    (sts)
	);

	lcgs_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.item         (item),
		.mu           (mu_eff),
		.ndocs        (ndocs),
		.result       (result),
		.result_valid (result_valid)
	);

endmodule

// File: rtl/lcgs_log2.sv
// iterative log2 unit: normalising shift then one squaring per cycle
// depends on lcgs_pkg
module lcgs_log2 import lcgs_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [LOG_X_W-1:0] x,
	output logic               busy,
	output logic               done,
	output logic [LOG_R_W-1:0] res
);

	logic               norm_q, sq_q, done_q;
	logic [LOG_X_W-1:0] x_q;
	logic [LOG_E_W-1:0] e_q;
	logic [MANT_W-1:0]  m_q;
	logic [LOG_F_W-1:0] frac_q;
	logic [4:0]         k_q;
	logic [2*MANT_W-1:0] sq;
	logic [MANT_W:0]    t;

	// square of the Q1.31 mantissa, truncated to Q2.31
	always_comb begin
		sq = m_q * m_q;
		t  = sq[2*MANT_W-1:MANT_W-1];
	end

	// phase control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			norm_q <= 1'b0;
			sq_q   <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				norm_q <= 1'b1;
				sq_q   <= 1'b0;
			end else if (norm_q && x_q[LOG_X_W-1]) begin
				norm_q <= 1'b0;
				sq_q   <= 1'b1;
			end else if (sq_q && k_q == '0) begin
				sq_q   <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// datapath: shift left one bit a cycle, then squaring steps
	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= x;
			e_q <= LOG_E_W'(LOG_X_W - 1);
		end else if (norm_q) begin
			if (x_q[LOG_X_W-1]) begin
				m_q <= x_q[LOG_X_W-1 -: MANT_W];
				k_q <= 5'(LOG_F_W - 1);
			end else begin
				x_q <= {x_q[LOG_X_W-2:0], 1'b0};
				e_q <= e_q - 1'b1;
			end
		end else if (sq_q) begin
			m_q    <= t[MANT_W] ? t[MANT_W:1] : t[MANT_W-1:0];
			frac_q <= {frac_q[LOG_F_W-2:0], t[MANT_W]};
			k_q    <= k_q - 1'b1;
		end
	end

	assign busy = norm_q | sq_q;
	assign done = done_q;
	assign res  = {e_q, frac_q};

endmodule

// File: rtl/lcgs_datapath.sv
// scorer datapath: term stores, merge pointers, log, multiply and divide
// depends on lcgs_pkg and lcgs_log2
module lcgs_datapath import lcgs_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  lcgs_cmd_t             cmd,
	output lcgs_sts_t             sts,
	input  lcgs_in_t              item,
	input  logic [MU_W-1:0]       mu,
	input  logic [DCNT_W-1:0]     ndocs,
	output lcgs_out_t             result,
	output logic                  result_valid
);

	typedef logic [TERM_W+TF_W-1:0] dword_t;

	// stores
	dword_t             dmem [2**DMEM_AW];
	logic [BG_W-1:0]    bgmem [VOCAB_SIZE];
	logic [TCNT_W-1:0]  cnt_q [MAX_DOCS];
	logic [SIZE_W-1:0]  size_q [MAX_DOCS];

	logic [DOC_W-1:0]   src_q;
	logic [TCNT_W-1:0]  cj_q, ci_q, m_q, k_q;
	logic [SIZE_W-1:0]  sj_q, si_q;
	logic [DCNT_W-1:0]  i_q;
	dword_t             src_rd_q, mdl_rd_q;
	logic [BG_W-1:0]    bg_q;
	logic [LOG_X_W-1:0] num_q;
	logic [LOG_R_W-1:0] ld_q;
	logic [63:0]        p_lo_q;
	logic [31:0]        p_hi_q;
	logic [MAG_W-1:0]   mag_q;
	logic [DVS_W-1:0]   rem_q;
	logic [QUO_W-1:0]   quo_q;
	logic [4:0]         div_cnt_q;
	logic               div_act_q, div_done_q;
	logic [SUM_W-1:0]   sum_q;
	logic               zero_q;
	lcgs_out_t          res_q;
	logic               valid_q;

	logic [DOC_W-1:0]   rd_doc;
	logic [TCNT_W-1:0]  cnt_rd;
	logic [SIZE_W-1:0]  size_rd;
	logic [SIZE_W:0]    size_sum;
	logic [LOG_X_W-1:0] den, num, log_x;
	logic [LOG_R_W-1:0] log_res, a;
	logic               log_busy, log_done;
	logic [63:0]        mag_full;
	logic [DVD_W-1:0]   prod;
	logic [DVS_W-1:0]   divisor;
	logic [DVS_W:0]     r2;
	logic               ge;
	logic [SUM_W:0]     sum_nxt;
	logic               sat;
	logic [DCNT_W-1:0]  last_idx;
	logic [TERM_W-1:0]  src_id, mdl_id;
	logic [TF_W-1:0]    src_tf, mdl_tf;

	assign src_id = src_rd_q[TERM_W+TF_W-1:TF_W];
	assign src_tf = src_rd_q[TF_W-1:0];
	assign mdl_id = mdl_rd_q[TERM_W+TF_W-1:TF_W];
	assign mdl_tf = mdl_rd_q[TF_W-1:0];

	// per-document count and size, one read index
	assign rd_doc   = cmd.use_i ? i_q[DOC_W-1:0] : item.doc_index;
	assign cnt_rd   = cnt_q[rd_doc];
	assign size_rd  = size_q[rd_doc];
	assign size_sum = {1'b0, size_rd} + (SIZE_W+1)'(item.term_freq);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int d = 0; d < MAX_DOCS; d++) begin
				cnt_q[d]  <= '0;
				size_q[d] <= '0;
			end
		end else if (cmd.wr_app && cnt_rd < TCNT_W'(MAX_TERMS)) begin
			cnt_q[rd_doc]  <= cnt_rd + 1'b1;
			size_q[rd_doc] <= size_sum[SIZE_W] ? SIZE_MAX : size_sum[SIZE_W-1:0];
		end
	end

	// document term memory: one write port, two registered read ports
	always_ff @(posedge clk) begin
		if (cmd.wr_app && cnt_rd < TCNT_W'(MAX_TERMS))
			dmem[{item.doc_index, cnt_rd[TIDX_W-1:0]}] <= {item.term_index, item.term_freq};
		src_rd_q <= dmem[{src_q, m_q[TIDX_W-1:0]}];
		mdl_rd_q <= dmem[{i_q[DOC_W-1:0], k_q[TIDX_W-1:0]}];
	end

	// background table, read at the current source term
	always_ff @(posedge clk) begin
		if (cmd.wr_bg)
			bgmem[item.term_index[VOCAB_AW-1:0]] <= item.background_prob;
		bg_q <= bgmem[src_id[VOCAB_AW-1:0]];
	end

	// request, model document and merge pointers
	always_ff @(posedge clk) begin
		if (cmd.req_load) begin
			src_q <= item.doc_index;
			cj_q  <= cnt_rd;
			sj_q  <= size_rd;
			i_q   <= '0;
		end else if (cmd.inc_i) begin
			i_q <= i_q + 1'b1;
		end
		if (cmd.doc_load) begin
			ci_q <= cnt_rd;
			si_q <= size_rd;
			m_q  <= '0;
			k_q  <= '0;
		end else begin
			if (cmd.inc_m)
				m_q <= m_q + 1'b1;
			if (cmd.inc_k)
				k_q <= k_q + 1'b1;
		end
	end

	// smoothed numerator and denominator, scaled by 2^16
	always_comb begin
		den = LOG_X_W'({(SIZE_W+1)'(si_q) + (SIZE_W+1)'(mu), 16'd0});
		num = LOG_X_W'(32'(bg_q) * 32'(mu));
		if (cmd.use_tf)
			num = num + LOG_X_W'({mdl_tf, 16'd0});
		log_x = cmd.log_sel_num ? num_q : den;
	end

	always_ff @(posedge clk) begin
		if (cmd.num_latch)
			num_q <= num;
		if (cmd.ld_latch)
			ld_q <= log_res;
	end

	lcgs_log2 u_log2 (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.log_start),
		.x      (log_x),
		.busy   (log_busy),
		.done   (log_done),
		.res    (log_res)
	);

	// ln magnitude: split product over two registers, then recombine
	assign a        = (ld_q > log_res) ? ld_q - log_res : '0;
	assign mag_full = {p_hi_q, 32'd0} + p_lo_q;
	assign prod     = DVD_W'(mag_q) * DVD_W'(src_tf);
	assign divisor  = {sj_q, 6'd0};

	always_ff @(posedge clk) begin
		if (cmd.mul1) begin
			p_lo_q <= 64'(a[31:0]) * 64'(LN2_Q28);
			p_hi_q <= 32'(a[LOG_R_W-1:32]) * 32'(LN2_Q28);
		end
		if (cmd.mul2)
			mag_q <= mag_full[MAG_W+27:28];
	end

	// restoring divider, one quotient bit a cycle
	assign r2 = {rem_q, quo_q[QUO_W-1]};
	assign ge = r2 >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_act_q  <= 1'b0;
			div_done_q <= 1'b0;
			div_cnt_q  <= '0;
		end else begin
			div_done_q <= 1'b0;
			if (cmd.div_start) begin
				div_act_q <= 1'b1;
				div_cnt_q <= 5'(QUO_W);
			end else if (div_act_q) begin
				div_cnt_q <= div_cnt_q - 1'b1;
				if (div_cnt_q == 5'd1) begin
					div_act_q  <= 1'b0;
					div_done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			rem_q <= DVS_W'(prod[DVD_W-1:QUO_W]);
			quo_q <= prod[QUO_W-1:0];
		end else if (div_act_q) begin
			rem_q <= ge ? DVS_W'(r2 - {1'b0, divisor}) : DVS_W'(r2);
			quo_q <= {quo_q[QUO_W-2:0], ge};
		end
	end

	// saturating cost accumulator and zero flag
	assign sum_nxt = {1'b0, sum_q} + (SUM_W+1)'(quo_q);

	always_ff @(posedge clk) begin
		if (cmd.doc_load) begin
			sum_q  <= '0;
			zero_q <= 1'b0;
		end else begin
			if (cmd.acc)
				sum_q <= (sum_nxt[SUM_W:SUM_W-1] != 2'b00) ? {1'b1, 32'd0}
					: sum_nxt[SUM_W-1:0];
			if (cmd.set_zero)
				zero_q <= 1'b1;
		end
	end

	// result register, shown for one cycle
	assign sat      = zero_q || (sum_q > {1'b0, 32'h8000_0000});
	assign last_idx = ({1'b0, src_q} == ndocs - 1'b1) ? ndocs - 2'd2 : ndocs - 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else
			valid_q <= cmd.emit;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			res_q.source_doc  <= src_q;
			res_q.model_doc   <= i_q[DOC_W-1:0];
			res_q.log_score   <= sat ? $signed(32'h8000_0000) : $signed(32'd0 - sum_q[31:0]);
			res_q.zero_factor <= zero_q;
			res_q.last        <= (i_q == last_idx);
		end
	end

	assign result       = res_q;
	assign result_valid = valid_q;

	// status to the controller
	always_comb begin
		sts.req_ok      = {1'b0, item.doc_index} < ndocs;
		sts.i_done      = i_q == ndocs;
		sts.i_is_src    = i_q == {1'b0, src_q};
		sts.m_end       = m_q == cj_q;
		sts.k_end       = k_q == ci_q;
		sts.a_lt_b      = src_id < mdl_id;
		sts.a_gt_b      = src_id > mdl_id;
		sts.src_tf_zero = src_tf == '0;
		sts.num_zero    = num_q == '0;
		sts.log_done    = log_done;
		sts.log_busy    = log_busy;
		sts.div_done    = div_done_q;
	end

endmodule

// File: rtl/lcgs_ctrl.sv
// scorer controller: request sequencing and sorted-list merge
// depends on lcgs_pkg and the assertion macro header
`include "lm_cross_generation_score_top_assert.svh"

module lcgs_ctrl import lcgs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [1:0] action,
	output logic       busy,
	output lcgs_cmd_t  cmd,
	input  lcgs_sts_t  sts
);

	typedef enum logic [12:0] {
		S_IDLE = 13'b0000000000001,
		S_DOC  = 13'b0000000000010,
		S_DEN  = 13'b0000000000100,
		S_DENW = 13'b0000000001000,
		S_RD   = 13'b0000000010000,
		S_CMP  = 13'b0000000100000,
		S_NUM  = 13'b0000001000000,
		S_NZ   = 13'b0000010000000,
		S_LOGN = 13'b0000100000000,
		S_MUL2 = 13'b0001000000000,
		S_MUL3 = 13'b0010000000000,
		S_DIV  = 13'b0100000000000,
		S_EMIT = 13'b1000000000000
	} state_t;

	state_t state_q, state_d;
	logic   match_q, match_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			match_q <= 1'b0;
		end else begin
			state_q <= state_d;
			match_q <= match_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d = state_q;
		match_d = match_q;
		cmd     = '0;
		cmd.use_i  = (state_q == S_DOC);
		cmd.use_tf = match_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					case (action)
						ACT_BG:  cmd.wr_bg  = 1'b1;
						ACT_APP: cmd.wr_app = 1'b1;
						ACT_SCORE: begin
							if (sts.req_ok) begin
								cmd.req_load = 1'b1;
								state_d      = S_DOC;
							end
						end
						default: ;
					endcase
				end
			end
			S_DOC: begin
				if (sts.i_done) begin
					state_d = S_IDLE;
				end else if (sts.i_is_src) begin
					cmd.inc_i = 1'b1;
				end else begin
					cmd.doc_load = 1'b1;
					state_d      = S_DEN;
				end
			end
			S_DEN: begin
				cmd.log_start = 1'b1;
				state_d       = S_DENW;
			end
			S_DENW: begin
				if (sts.log_done) begin
					cmd.ld_latch = 1'b1;
					state_d      = S_RD;
				end
			end
			S_RD: state_d = S_CMP;
			S_CMP: begin
				if (sts.m_end) begin
					state_d = S_EMIT;
				end else if (!sts.k_end && sts.a_gt_b) begin
					cmd.inc_k = 1'b1;
					state_d   = S_RD;
				end else begin
					match_d = !sts.k_end && !sts.a_lt_b;
					if (sts.src_tf_zero) begin
						cmd.inc_m = 1'b1;
						cmd.inc_k = !sts.k_end && !sts.a_lt_b;
						state_d   = S_RD;
					end else begin
						state_d = S_NUM;
					end
				end
			end
			S_NUM: begin
				cmd.num_latch = 1'b1;
				state_d       = S_NZ;
			end
			S_NZ: begin
				if (sts.num_zero) begin
					cmd.set_zero = 1'b1;
					cmd.inc_m    = 1'b1;
					cmd.inc_k    = match_q;
					state_d      = S_RD;
				end else begin
					cmd.log_start   = 1'b1;
					cmd.log_sel_num = 1'b1;
					state_d         = S_LOGN;
				end
			end
			S_LOGN: begin
				if (sts.log_done) begin
					cmd.mul1 = 1'b1;
					state_d  = S_MUL2;
				end
			end
			S_MUL2: begin
				cmd.mul2 = 1'b1;
				state_d  = S_MUL3;
			end
			S_MUL3: begin
				cmd.div_start = 1'b1;
				state_d       = S_DIV;
			end
			S_DIV: begin
				if (sts.div_done) begin
					cmd.acc   = 1'b1;
					cmd.inc_m = 1'b1;
					cmd.inc_k = match_q;
					state_d   = S_RD;
				end
			end
			S_EMIT: begin
				cmd.emit  = 1'b1;
				cmd.inc_i = 1'b1;
				state_d   = S_DOC;
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign busy = (state_q != S_IDLE);

	// checks
	`LCGS_ASSERT_IMP(a_log_idle, clk, arst_n, cmd.log_start, !sts.log_busy, "log unit restarted while busy")
	`LCGS_ASSERT_NXT(a_emit_single, clk, arst_n, cmd.emit, !cmd.emit, "results in consecutive cycles")
	`LCGS_ASSERT_NXT(a_div_run, clk, arst_n, cmd.div_start, !sts.div_done && !cmd.acc, "divider done at once")
	`LCGS_ASSERT_IMP(a_emit_busy, clk, arst_n, cmd.emit, busy && !sts.log_busy, "result outside a request")

endmodule
